### src/nfa_range_epsilon_stepper_core_defines.svh
// Assertion macros for the checker file.
`ifndef NFA_RANGE_EPSILON_STEPPER_CORE_DEFINES_SVH
`define NFA_RANGE_EPSILON_STEPPER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define NRES_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define NRES_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/nres_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nres_pkg
// Shared types, codes and default sizes of the NFA range/epsilon stepper.
// ----------------------------------------------------------------------------
package nres_pkg;

	localparam int NRES_NUM_STATES      = 16;
	localparam int NRES_SLOTS_PER_STATE = 4;
	localparam int NRES_RANGES_PER_SLOT = 4;
	localparam int NRES_CHAR_BITS       = 21;

	localparam logic [20:0] NRES_EPS_RESET = 21'h1FFFFF;

	typedef enum logic [2:0] {
		CMD_BEGIN = 3'd0,
		CMD_HDR   = 3'd1,
		CMD_RANGE = 3'd2,
		CMD_STEP  = 3'd3,
		CMD_CLEAR = 3'd4
	} nres_cmd_t;

	typedef enum logic [2:0] {
		STAT_DONE     = 3'd0,
		STAT_REJECT   = 3'd1,
		STAT_ACCEPT   = 3'd2,
		STAT_ACC_MORE = 3'd3,
		STAT_NOT_MORE = 3'd4
	} nres_status_t;

	typedef enum logic [1:0] {
		CFG_START   = 2'd0,
		CFG_ACCEPT  = 2'd1,
		CFG_EPSILON = 2'd2
	} nres_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PICK,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} nres_state_t;

endpackage

### src/nres_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nres_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nres_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/nfa_range_epsilon_stepper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_range_epsilon_stepper_core
// NFA stepper: slot headers and character ranges in RAM, epsilon closure.
// ----------------------------------------------------------------------------
// Begin, header write, range write, clear and unknown commands show their
// result beat in the cycle after they are taken. A step walks each state
// it expands: every slot and every range of that state is read from the range
// RAM, one range per cycle, between a pick state before and a drain state
// after. A step expands each active state once for the character and then
// each state of the new set once for epsilon. The single read port of the
// range RAM sets the pace of a step. Input is stalled while a step runs.
module nfa_range_epsilon_stepper_core
	import nres_pkg::*;
#(
	parameter int NUM_STATES      = NRES_NUM_STATES,
	parameter int SLOTS_PER_STATE = NRES_SLOTS_PER_STATE,
	parameter int RANGES_PER_SLOT = NRES_RANGES_PER_SLOT,
	parameter int CHAR_BITS       = NRES_CHAR_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [20:0] cfg_data,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [3:0]  from_state,
	input  logic [1:0]  slot,
	input  logic [3:0]  dest_state,
	input  logic        negative,
	input  logic        slot_valid,
	input  logic [2:0]  range_count,
	input  logic [1:0]  range_index,
	input  logic [20:0] range_low,
	input  logic [20:0] range_high,
	input  logic [20:0] character,
	input  logic        last_char,
	// results
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] active_states
);

	localparam int SW    = $clog2(NUM_STATES);
	localparam int KW    = (SLOTS_PER_STATE > 1) ? $clog2(SLOTS_PER_STATE) : 1;
	localparam int RW    = (RANGES_PER_SLOT > 1) ? $clog2(RANGES_PER_SLOT) : 1;
	localparam int CW    = $clog2(RANGES_PER_SLOT + 1);
	localparam int NSLOT = NUM_STATES * SLOTS_PER_STATE;
	localparam int NRNG  = NSLOT * RANGES_PER_SLOT;
	localparam int HAW   = (NSLOT > 1) ? $clog2(NSLOT) : 1;
	localparam int RAW   = (NRNG > 1) ? $clog2(NRNG) : 1;
	localparam int HDW   = 5 + CW;     // neg, dest[3:0], count
	localparam int RDW   = 2 * CHAR_BITS;

	nres_state_t state_q, state_d;

	logic [3:0]            start_q;
	logic [15:0]           acc_mask_q;
	logic [20:0]           eps_q;
	logic [CHAR_BITS-1:0]  char_q;
	logic                  last_q;
	logic                  phase_q;   // 0 character pass, 1 epsilon pass
	logic [NUM_STATES-1:0] active_q;
	logic [NUM_STATES-1:0] next_q;
	logic [NUM_STATES-1:0] done_q;
	logic [NSLOT-1:0]      hvalid_q;
	logic [SW-1:0]         cur_q;
	logic [KW-1:0]         k_q;
	logic [RW-1:0]         r_q;

	logic                  v_s1;
	logic                  lastr_s1;
	logic [RW-1:0]         r_s1;
	logic [HAW-1:0]        idx_s1;
	logic                  ins_q;

	logic                  out_valid_q;
	logic [2:0]            status_q;
	logic [15:0]           active_out_q;

	logic in_acc, out_free, issue, scan_last;

	// --------------------------------------------------------------- handshakes
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_acc    = in_valid && !in_stall;

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign active_states = active_out_q;

	// ------------------------------------------------------------ write decode
	logic from_ok, slot_ok, ridx_ok;
	logic [HAW-1:0] wr_idx;
	logic [CW-1:0]  cnt_sat;

	assign from_ok = 32'(from_state) < NUM_STATES;
	assign slot_ok = 32'(slot) < SLOTS_PER_STATE;
	assign ridx_ok = 32'(range_index) < RANGES_PER_SLOT;
	assign wr_idx  = HAW'(32'(from_state) * SLOTS_PER_STATE + 32'(slot));
	assign cnt_sat = (32'(range_count) > RANGES_PER_SLOT) ? CW'(RANGES_PER_SLOT)
		: CW'(range_count);

	logic hdr_we, rng_we;
	assign hdr_we = in_acc && (command == CMD_HDR) && from_ok && slot_ok;
	assign rng_we = in_acc && (command == CMD_RANGE) && from_ok && slot_ok && ridx_ok;

	logic [RAW-1:0] rng_waddr;
	assign rng_waddr = RAW'(32'(wr_idx) * RANGES_PER_SLOT + 32'(range_index));

	// ------------------------------------------------------------- read side
	logic [HAW-1:0] rd_idx;
	logic [RAW-1:0] rng_raddr;
	logic [HDW-1:0] hdr_rdata;
	logic [RDW-1:0] rng_rdata;

	assign rd_idx    = HAW'(32'(cur_q) * SLOTS_PER_STATE + 32'(k_q));
	assign rng_raddr = RAW'(32'(rd_idx) * RANGES_PER_SLOT + 32'(r_q));
	assign scan_last = (k_q == KW'(SLOTS_PER_STATE - 1)) && (r_q == RW'(RANGES_PER_SLOT - 1));

	nres_ram #(.WIDTH(HDW), .DEPTH(NSLOT)) u_hdr_ram (
		.clk   (clk),
		.we    (hdr_we),
		.waddr (wr_idx),
		.wdata ({negative, dest_state, cnt_sat}),
		.re    (issue && (r_q == '0)),
		.raddr (rd_idx),
		.rdata (hdr_rdata)
	);

	nres_ram #(.WIDTH(RDW), .DEPTH(NRNG)) u_rng_ram (
		.clk   (clk),
		.we    (rng_we),
		.waddr (rng_waddr),
		.wdata ({CHAR_BITS'(range_high), CHAR_BITS'(range_low)}),
		.re    (issue),
		.raddr (rng_raddr),
		.rdata (rng_rdata)
	);

	// --------------------------------------------------------- slot evaluate
	logic                 h_neg;
	logic [3:0]           h_dest;
	logic [CW-1:0]        h_cnt;
	logic [CHAR_BITS-1:0] r_lo, r_hi, cmp_ch;
	logic                 in_now, ins_acc, slot_hit;
	logic [NUM_STATES-1:0] add_vec;

	assign {h_neg, h_dest, h_cnt} = hdr_rdata;
	assign {r_hi, r_lo}           = rng_rdata;
	assign cmp_ch  = phase_q ? CHAR_BITS'(eps_q) : char_q;
	assign in_now  = (CW'(r_s1) < h_cnt) && (cmp_ch >= r_lo) && (cmp_ch <= r_hi);
	assign ins_acc = ((r_s1 == '0) ? 1'b0 : ins_q) | in_now;
	assign slot_hit = v_s1 && lastr_s1 && hvalid_q[idx_s1] && (h_neg ^ ins_acc);

	always_comb begin
		for (int i = 0; i < NUM_STATES; i++) begin
			add_vec[i] = slot_hit && (32'(h_dest) == i);
		end
	end

	// ------------------------------------------------------------ state pick
	logic [NUM_STATES-1:0] pick_mask;
	logic                  pick_found;
	logic [SW-1:0]         pick_idx;

	assign pick_mask  = (phase_q ? next_q : active_q) & ~done_q;
	assign pick_found = |pick_mask;

	always_comb begin
		pick_idx = '0;
		for (int i = NUM_STATES - 1; i >= 0; i--) begin
			if (pick_mask[i]) begin
				pick_idx = SW'(i);
			end
		end
	end

	// ---------------------------------------------------------- step status
	logic [15:0] next_low;
	logic [2:0]  step_status;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			next_low[i] = (i < NUM_STATES) ? next_q[i % NUM_STATES] : 1'b0;
		end
	end

	always_comb begin
		priority if (!(|next_q)) begin
			step_status = STAT_REJECT;
		end else if (|(next_low & acc_mask_q)) begin
			step_status = last_q ? STAT_ACCEPT : STAT_ACC_MORE;
		end else begin
			step_status = last_q ? STAT_REJECT : STAT_NOT_MORE;
		end
	end

	logic [15:0] active_low;
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			active_low[i] = (i < NUM_STATES) ? active_q[i % NUM_STATES] : 1'b0;
		end
	end

	// set shown after a begin
	logic [15:0] start_low;
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			start_low[i] = (i < NUM_STATES) && (32'(start_q) == i);
		end
	end

	// ------------------------------------------------------------ next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && command == CMD_STEP) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				if (pick_found) begin
					state_d = ST_SCAN;
				end else if (phase_q) begin
					state_d = ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_PICK;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// --------------------------------------------------------------- outputs
	always_comb begin
		in_stall = 1'b1;
		issue    = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_stall = !out_free;
			ST_SCAN:  issue    = 1'b1;
			default: begin
				in_stall = 1'b1;
				issue    = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= '0;
			acc_mask_q  <= '0;
			eps_q       <= NRES_EPS_RESET;
			active_q    <= NUM_STATES'(1);
			hvalid_q    <= '0;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_START:   start_q    <= cfg_data[3:0];
					CFG_ACCEPT:  acc_mask_q <= cfg_data[15:0];
					CFG_EPSILON: eps_q      <= cfg_data;
					default: ;
				endcase
			end

			priority if ((in_acc && command != CMD_STEP) || state_q == ST_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (in_acc) begin
				unique case (command)
					CMD_BEGIN: begin
						for (int i = 0; i < NUM_STATES; i++) begin
							active_q[i] <= (32'(start_q) == i);
						end
					end
					CMD_HDR:   if (from_ok && slot_ok) hvalid_q[wr_idx] <= slot_valid;
					CMD_CLEAR: hvalid_q <= '0;
					default: ;
				endcase
			end

			if (state_q == ST_FINISH) begin
				active_q <= next_q;
			end
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			char_q  <= CHAR_BITS'(character);
			last_q  <= last_char;
			phase_q <= 1'b0;
			next_q  <= '0;
			done_q  <= '0;
			status_q     <= STAT_DONE;
			active_out_q <= (command == CMD_BEGIN) ? start_low : active_low;
		end

		if (state_q == ST_PICK) begin
			if (pick_found) begin
				cur_q <= pick_idx;
				done_q[pick_idx] <= 1'b1;
			end else if (!phase_q) begin
				phase_q <= 1'b1;
				done_q  <= '0;
			end
			k_q <= '0;
			r_q <= '0;
		end

		if (issue) begin
			if (r_q == RW'(RANGES_PER_SLOT - 1)) begin
				r_q <= '0;
				k_q <= k_q + KW'(1);
			end else begin
				r_q <= r_q + RW'(1);
			end
		end

		r_s1     <= r_q;
		lastr_s1 <= (r_q == RW'(RANGES_PER_SLOT - 1));
		idx_s1   <= rd_idx;

		if (v_s1) begin
			ins_q  <= ins_acc;
			next_q <= next_q | add_vec;
		end

		if (state_q == ST_FINISH) begin
			status_q     <= step_status;
			active_out_q <= next_low;
		end
	end

endmodule

### src/nres_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nres_checker
// Port-level checks of the stepper core, bound to every instance.
// ----------------------------------------------------------------------------
`include "nfa_range_epsilon_stepper_core_defines.svh"

module nres_checker
	import nres_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [2:0]  command,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [15:0] active_states
);

	// Every non-step command answers with a done beat on the very next edge.
	`NRES_ASSERT_NXT(a_quick_cmd, in_valid && !in_stall && command != CMD_STEP, out_valid && status == STAT_DONE, "non-step command beat missing")

	// A step occupies the core: no new beat right after it.
	`NRES_ASSERT_NXT(a_step_busy, in_valid && !in_stall && command == CMD_STEP, in_stall, "input taken during step")

	// Accepting status needs some visible active state.
	`NRES_ASSERT_NOW(a_acc_set, out_valid && (status == STAT_ACCEPT || status == STAT_ACC_MORE), active_states != 16'd0, "accepting with empty set")

	// A stalled result beat holds.
	`NRES_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(active_states), "stalled beat changed")

endmodule

bind nfa_range_epsilon_stepper_core nres_checker u_nres_checker (.*);

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for nfa_range_epsilon_stepper_core. It builds transition
// tables through header and range writes, runs strings through begin/step
// commands and predicts each status/active-set beat with its own NFA
// simulation, including the epsilon closure. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;
	import nres_pkg::*;

	localparam int NSLOT     = NRES_NUM_STATES * NRES_SLOTS_PER_STATE;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [2:0]  command;
		logic [3:0]  from_state;
		logic [1:0]  slot;
		logic [3:0]  dest_state;
		logic        negative;
		logic        slot_valid;
		logic [2:0]  range_count;
		logic [1:0]  range_index;
		logic [20:0] range_low;
		logic [20:0] range_high;
		logic [20:0] character;
		logic        last_char;
	} nfa_cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] active;
	} nfa_report_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [20:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  command;
	logic [3:0]  from_state;
	logic [1:0]  slot;
	logic [3:0]  dest_state;
	logic        negative;
	logic        slot_valid;
	logic [2:0]  range_count;
	logic [1:0]  range_index;
	logic [20:0] range_low;
	logic [20:0] range_high;
	logic [20:0] character;
	logic        last_char;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [15:0] active_states;

	nfa_range_epsilon_stepper_core dut (.*);

	// own copy of the automaton
	logic        hdr_valid [NSLOT];
	logic        hdr_neg   [NSLOT];
	logic [3:0]  hdr_dest  [NSLOT];
	logic [2:0]  hdr_cnt   [NSLOT];
	logic [20:0] rng_lo    [NSLOT][NRES_RANGES_PER_SLOT];
	logic [20:0] rng_hi    [NSLOT][NRES_RANGES_PER_SLOT];
	logic        rng_set   [NSLOT][NRES_RANGES_PER_SLOT];
	logic [15:0] cur_active;
	logic [3:0]  reg_start;
	logic [15:0] reg_accept;
	logic [20:0] reg_eps;

	nfa_report_t pending_reports[$];
	int mismatches;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	bit hold_go;
	int quiet_cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic slot_hits(int idx, logic [20:0] ch);
		logic in_rng;
		in_rng = 1'b0;
		for (int r = 0; r < hdr_cnt[idx]; r++)
			if (ch >= rng_lo[idx][r] && ch <= rng_hi[idx][r])
				in_rng = 1'b1;
		return hdr_neg[idx] ? !in_rng : in_rng;
	endfunction

	function automatic nfa_report_t advance_nfa(nfa_cmd_t c);
		nfa_report_t rep;
		logic [15:0] nxt;
		logic        grew;
		int          idx;
		int          cnt;
		rep.status = STAT_DONE;
		case (c.command)
			CMD_BEGIN: cur_active = 16'd1 << reg_start;
			CMD_HDR: begin
				idx = c.from_state * NRES_SLOTS_PER_STATE + c.slot;
				cnt = (c.range_count > NRES_RANGES_PER_SLOT) ? NRES_RANGES_PER_SLOT
					: c.range_count;
				hdr_dest[idx]  = c.dest_state;
				hdr_neg[idx]   = c.negative;
				hdr_valid[idx] = c.slot_valid;
				hdr_cnt[idx]   = cnt[2:0];
			end
			CMD_RANGE: begin
				idx = c.from_state * NRES_SLOTS_PER_STATE + c.slot;
				rng_lo[idx][c.range_index]  = c.range_low;
				rng_hi[idx][c.range_index]  = c.range_high;
				rng_set[idx][c.range_index] = 1'b1;
			end
			CMD_STEP: begin
				nxt = '0;
				for (int s = 0; s < NRES_NUM_STATES; s++)
					if (cur_active[s])
						for (int k = 0; k < NRES_SLOTS_PER_STATE; k++) begin
							idx = s * NRES_SLOTS_PER_STATE + k;
							if (hdr_valid[idx] && slot_hits(idx, c.character))
								nxt[hdr_dest[idx]] = 1'b1;
						end
				// epsilon closure to a fixpoint
				do begin
					grew = 1'b0;
					for (int s = 0; s < NRES_NUM_STATES; s++)
						if (nxt[s])
							for (int k = 0; k < NRES_SLOTS_PER_STATE; k++) begin
								idx = s * NRES_SLOTS_PER_STATE + k;
								if (hdr_valid[idx] && !nxt[hdr_dest[idx]]
										&& slot_hits(idx, reg_eps)) begin
									nxt[hdr_dest[idx]] = 1'b1;
									grew = 1'b1;
								end
							end
				end while (grew);
				cur_active = nxt;
				if (nxt == '0)
					rep.status = STAT_REJECT;
				else if ((nxt & reg_accept) != '0)
					rep.status = c.last_char ? STAT_ACCEPT : STAT_ACC_MORE;
				else
					rep.status = c.last_char ? STAT_REJECT : STAT_NOT_MORE;
			end
			CMD_CLEAR: begin
				for (int i = 0; i < NSLOT; i++)
					hdr_valid[i] = 1'b0;
			end
			default: ;
		endcase
		rep.active = cur_active;
		return rep;
	endfunction

	task automatic send_cmd(input nfa_cmd_t c);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		command     <= c.command;
		from_state  <= c.from_state;
		slot        <= c.slot;
		dest_state  <= c.dest_state;
		negative    <= c.negative;
		slot_valid  <= c.slot_valid;
		range_count <= c.range_count;
		range_index <= c.range_index;
		range_low   <= c.range_low;
		range_high  <= c.range_high;
		character   <= c.character;
		last_char   <= c.last_char;
		in_valid    <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_reports.push_back(advance_nfa(c));
	endtask

	function automatic nfa_cmd_t noise_cmd();
		nfa_cmd_t   c;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		c = raw[$bits(nfa_cmd_t)-1:0];
		return c;
	endfunction

	task automatic put_range(int st, int sl, int ri, logic [20:0] lo, logic [20:0] hi);
		nfa_cmd_t c;
		c = noise_cmd();
		c.command = CMD_RANGE;
		c.from_state = 4'(st);
		c.slot = 2'(sl);
		c.range_index = 2'(ri);
		c.range_low = lo;
		c.range_high = hi;
		send_cmd(c);
	endtask

	// a valid header never exposes a range that was not written
	task automatic put_header(int st, int sl, int dst, bit neg, bit vld, int cnt);
		nfa_cmd_t c;
		int       idx;
		idx = st * NRES_SLOTS_PER_STATE + sl;
		if (vld)
			for (int r = 0; r < cnt && r < NRES_RANGES_PER_SLOT; r++)
				if (!rng_set[idx][r])
					put_range(st, sl, r, 21'd0, 21'd0);
		c = noise_cmd();
		c.command = CMD_HDR;
		c.from_state = 4'(st);
		c.slot = 2'(sl);
		c.dest_state = 4'(dst);
		c.negative = neg;
		c.slot_valid = vld;
		c.range_count = 3'(cnt);
		send_cmd(c);
	endtask

	task automatic put_simple(logic [2:0] op, logic [20:0] ch, bit last);
		nfa_cmd_t c;
		c = noise_cmd();
		c.command = op;
		c.character = ch;
		c.last_char = last;
		send_cmd(c);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(nres_cfg_t idx, logic [20:0] d);
		drain();
		cfg_index <= idx;
		cfg_data  <= d;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_START:   reg_start = d[3:0];
			CFG_ACCEPT:  reg_accept = d[15:0];
			CFG_EPSILON: reg_eps = d;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (hold_go) begin
			hold_left = HOLD_CYCLES;
			hold_go = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		nfa_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result beat with nothing expected: status %0d active %h",
						status, active_states);
			end else begin
				want = pending_reports.pop_front();
				if (status !== want.status || active_states !== want.active) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: status exp %0d got %0d, active exp %h got %h",
							want.status, status, want.active, active_states);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic test_reset_state();
		put_simple(CMD_STEP, 21'd5, 1'b0);
		put_simple(CMD_BEGIN, 21'd0, 1'b0);
		put_simple(CMD_STEP, 21'h1FFFFF, 1'b1);
	endtask

	task automatic test_directed();
		write_reg(CFG_EPSILON, 21'd7);
		write_reg(CFG_ACCEPT, 21'h8004);
		write_reg(CFG_START, 21'd0);
		put_range(0, 0, 0, 21'd1, 21'd3);
		put_range(0, 0, 1, 21'd10, 21'd9);          // reversed: never hits
		put_header(0, 0, 1, 1'b0, 1'b1, 2);
		put_range(1, 0, 0, 21'd7, 21'd7);           // epsilon hop 1 -> 2
		put_header(1, 0, 2, 1'b0, 1'b1, 1);
		put_header(2, 1, 15, 1'b1, 1'b1, 0);        // negative, no ranges: always
		put_range(2, 2, 0, 21'h1FFFFF, 21'h1FFFFF);
		put_header(2, 2, 3, 1'b0, 1'b1, 7);         // count saturates
		put_simple(CMD_BEGIN, 21'd0, 1'b0);
		put_simple(CMD_STEP, 21'd2, 1'b0);
		put_simple(CMD_STEP, 21'd0, 1'b1);
		put_simple(CMD_BEGIN, 21'd0, 1'b0);
		put_simple(CMD_STEP, 21'd9, 1'b1);
		for (int op = 5; op < 8; op++)
			put_simple(3'(op), 21'd0, 1'b0);
		put_simple(CMD_CLEAR, 21'd0, 1'b0);
		put_simple(CMD_BEGIN, 21'd0, 1'b0);
		put_simple(CMD_STEP, 21'd2, 1'b1);
	endtask

	task automatic test_random_strings(int n_items);
		int  sent;
		int  len;
		int  st;
		int  lo;
		logic [20:0] ch;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				// noise beat; a valid header goes through the guarded path
				nfa_cmd_t c;
				c = noise_cmd();
				if (c.command == CMD_HDR)
					put_header(c.from_state, c.slot, c.dest_state, c.negative,
						c.slot_valid, c.range_count);
				else
					send_cmd(c);
				sent++;
				continue;
			end
			if ($urandom_range(3) == 0) begin
				put_simple(CMD_CLEAR, 21'd0, 1'b0);
				sent++;
			end
			repeat ($urandom_range(2, 6)) begin
				st = $urandom_range(0, 5);
				lo = $urandom_range(0, 15);
				case ($urandom_range(9))
					0: put_range(st, $urandom_range(3), $urandom_range(3), 21'(lo + 3),
						21'(lo));
					1: put_range(st, $urandom_range(3), $urandom_range(3), 21'($urandom),
						21'($urandom));
					default: put_range(st, $urandom_range(3), $urandom_range(3), 21'(lo),
						21'(lo + $urandom_range(0, 4)));
				endcase
				put_header(st, $urandom_range(3), $urandom_range(0, 5),
					$urandom_range(5) == 0, $urandom_range(7) != 0, $urandom_range(7));
				sent += 2;
			end
			put_simple(CMD_BEGIN, 21'd0, 1'b0);
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(9))
					0: ch = reg_eps;
					1: ch = 21'($urandom);
					default: ch = 21'($urandom_range(0, 15));
				endcase
				put_simple(CMD_STEP, ch, i == len - 1);
			end
			sent += len + 1;
		end
	endtask

	task automatic test_backpressure();
		drain();
		hold_go = 1'b1;
		for (int i = 0; i < 30; i++)
			put_range(i % 16, i % 4, 0, 21'($urandom), 21'($urandom));
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		command     <= '0;
		from_state  <= '0;
		slot        <= '0;
		dest_state  <= '0;
		negative    <= 1'b0;
		slot_valid  <= 1'b0;
		range_count <= '0;
		range_index <= '0;
		range_low   <= '0;
		range_high  <= '0;
		character   <= '0;
		last_char   <= 1'b0;
		mismatches = 0;
		quiet_cycles = 0;
		hold_left = 0;
		hold_go = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		cur_active = 16'd1;
		reg_start = '0;
		reg_accept = '0;
		reg_eps = NRES_EPS_RESET;
		for (int i = 0; i < NSLOT; i++) begin
			hdr_valid[i] = 1'b0;
			hdr_neg[i] = 1'b0;
			hdr_dest[i] = '0;
			hdr_cnt[i] = '0;
			for (int r = 0; r < NRES_RANGES_PER_SLOT; r++) begin
				rng_lo[i][r] = '0;
				rng_hi[i][r] = '0;
				rng_set[i][r] = 1'b0;
			end
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 37;
		recv_idle_pct = 56;
		test_reset_state();
		test_directed();
		test_random_strings(300);

		write_reg(CFG_START, 21'd15);
		write_reg(CFG_ACCEPT, 21'hFFFF);
		write_reg(CFG_EPSILON, 21'd0);
		send_idle_pct = 56;
		recv_idle_pct = 37;
		test_random_strings(300);
		test_backpressure();

		write_reg(CFG_START, 21'd1);
		write_reg(CFG_ACCEPT, 21'h0000);
		write_reg(CFG_ACCEPT, 21'h0024);
		write_reg(CFG_EPSILON, 21'h1FFFFF);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_strings(300);

		drain();
		repeat (50) @(posedge clk);
		if (pending_reports.size() != 0) begin
			mismatches++;
			$display("%0d expected results never arrived", pending_reports.size());
		end
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### nfa_range_epsilon_stepper_core.f
+incdir+src
src/nres_pkg.sv
src/nres_ram.sv
src/nfa_range_epsilon_stepper_core.sv
src/nres_checker.sv
verif/tb.sv
